// ===== design/cs_pkg.sv =====
package cs_pkg;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MEAS = 2'd1;
  localparam logic [1:0] M_DOWN = 2'd2;

  localparam logic [1:0] CFG_VARIANT = 2'd0;
  localparam logic [1:0] CFG_SER_HI  = 2'd1;
  localparam logic [1:0] CFG_SER_MID = 2'd2;
  localparam logic [1:0] CFG_SER_LO  = 2'd3;

  localparam logic [15:0] K_START_PER  = 16'h21B1;
  localparam logic [15:0] K_READ_MEAS  = 16'hEC05;
  localparam logic [15:0] K_STOP_PER   = 16'h3F86;
  localparam logic [15:0] K_SERIAL     = 16'h3682;
  localparam logic [15:0] K_DREADY     = 16'hE4B8;
  localparam logic [15:0] K_SET_TOFF   = 16'h241D;
  localparam logic [15:0] K_GET_TOFF   = 16'h2318;
  localparam logic [15:0] K_SET_ALT    = 16'h2427;
  localparam logic [15:0] K_GET_ALT    = 16'h2322;
  localparam logic [15:0] K_PRESSURE   = 16'hE000;
  localparam logic [15:0] K_FRC        = 16'h362F;
  localparam logic [15:0] K_SET_ASC    = 16'h2416;
  localparam logic [15:0] K_GET_ASC    = 16'h2313;
  localparam logic [15:0] K_START_LP   = 16'h21AC;
  localparam logic [15:0] K_PERSIST    = 16'h3615;
  localparam logic [15:0] K_SELFTEST   = 16'h3639;
  localparam logic [15:0] K_FACTORY    = 16'h3632;
  localparam logic [15:0] K_REINIT     = 16'h3646;
  localparam logic [15:0] K_PWR_DOWN   = 16'h36E0;
  localparam logic [15:0] K_WAKE       = 16'h36F6;
  localparam logic [15:0] K_VARIANT    = 16'h202F;
  localparam logic [15:0] K_SET_TGT    = 16'h243A;
  localparam logic [15:0] K_GET_TGT    = 16'h233F;
  localparam logic [15:0] K_SINGLE     = 16'h219D;
  localparam logic [15:0] K_SINGLE_RHT = 16'h2196;
  localparam logic [15:0] K_SET_INIT   = 16'h2445;
  localparam logic [15:0] K_GET_INIT   = 16'h2340;
  localparam logic [15:0] K_SET_STD    = 16'h244E;
  localparam logic [15:0] K_GET_STD    = 16'h234B;

  localparam logic [15:0] DEF_TOFF = 16'd1498;
  localparam logic [15:0] DEF_TGT  = 16'd400;
  localparam logic [15:0] DEF_INIT = 16'd44;
  localparam logic [15:0] DEF_STD  = 16'd156;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  data_byte;
    logic [15:0] co2_sample;
    logic [15:0] temp_sample;
    logic [15:0] humidity_sample;
  } in_item_t;

  typedef struct packed {
    logic       ack;
    logic [7:0] read_byte;
    logic       data_ready_flag;
    logic [1:0] mode;
  } out_item_t;

  function automatic logic [7:0] crc8(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] c;
    c = 8'hFF ^ hi;
    for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
    c = c ^ lo;
    for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
    return c;
  endfunction

endpackage

// ===== design/co2_sensor_i2c_command_engine_top.sv =====
// Command engine for the bus target side of a gas sensor.
// Input items arrive on s_axis (bus events and 1 ms ticks); each one yields
// exactly one result item on m_axis, in order.
// Configuration registers (variant, three serial words) are written on the
// cfg channel, which is always ready; write only while no result is pending.
// Each result is loaded into the result register as its item is accepted.
// Throughput is one item per cycle without stalls: the whole command decode,
// CRC and state update sit between the state and result registers.
// When the receiver stalls, the result register holds its item and s_axis
// stays ready only while that register is empty or being drained, so a new
// item may enter in the same cycle that the old result leaves.
// Reset clears all mode, timer, flag and calibration state to its defaults
// and empties the result register.
module co2_sensor_i2c_command_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], data_byte[10:3], co2[26:11], temp[42:27], humidity[58:43]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ack[0], read_byte[8:1], data_ready_flag[9], mode[11:10]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic              step;
  cs_pkg::in_item_t  item;
  cs_pkg::out_item_t res, res_q;
  logic              ov_q;
  logic [3:0]        var_q;
  logic [15:0]       shi_q, smid_q, slo_q;

  assign s_axis_tready = !ov_q || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign item.operation = s_axis_tdata[2:0];
  assign item.data_byte = s_axis_tdata[10:3];
  assign item.co2_sample = s_axis_tdata[26:11];
  assign item.temp_sample = s_axis_tdata[42:27];
  assign item.humidity_sample = s_axis_tdata[58:43];

  cs_engine u_engine (
    .clk_i, .rst_ni, .step_i(step), .item_i(item), .variant_i(var_q),
    .ser_hi_i(shi_q), .ser_mid_i(smid_q), .ser_lo_i(slo_q), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      var_q <= 4'd1; shi_q <= 16'd1; smid_q <= 16'd2; slo_q <= 16'd3;
    end else begin
      if (step) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          cs_pkg::CFG_VARIANT: var_q <= cfg_data_i[3:0];
          cs_pkg::CFG_SER_HI:  shi_q <= cfg_data_i;
          cs_pkg::CFG_SER_MID: smid_q <= cfg_data_i;
          cs_pkg::CFG_SER_LO:  slo_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {4'd0, res_q.mode, res_q.data_ready_flag, res_q.read_byte, res_q.ack};

endmodule

// ===== design/cs_engine.sv =====
module cs_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cs_pkg::in_item_t  item_i,
  input  logic [3:0]        variant_i,
  input  logic [15:0]       ser_hi_i,
  input  logic [15:0]       ser_mid_i,
  input  logic [15:0]       ser_lo_i,
  output cs_pkg::out_item_t res_o
);

  logic [1:0]  mode_q, mode_d;
  logic [2:0]  wcnt_q, wcnt_d;
  logic [7:0]  wb_q [4], wb_d [4];
  logic [15:0] cmd_q, cmd_d;
  logic [7:0]  rsp_q [9], rsp_d [9];
  logic [3:0]  rlen_q, rlen_d, ridx_q, ridx_d;
  logic        f_dr_q, f_dr_d, f_first_q, f_first_d, f_lp_q, f_lp_d, f_ss_q, f_ss_d;
  logic        f_rht_q, f_rht_d, f_meas_q, f_meas_d, f_pers_q, f_pers_d;
  logic [13:0] busy_q, busy_d;
  logic [14:0] mms_q, mms_d;
  logic [15:0] act_q [6], act_d [6];
  logic        asc_q, asc_d;
  logic [15:0] sto_q [6], sto_d [6];
  logic [14:0] mms_dec;

  function automatic logic is_ext(input logic [15:0] c);
    return c == cs_pkg::K_PWR_DOWN || c == cs_pkg::K_WAKE || c == cs_pkg::K_SINGLE ||
           c == cs_pkg::K_SINGLE_RHT || c == cs_pkg::K_SET_INIT ||
           c == cs_pkg::K_GET_INIT || c == cs_pkg::K_SET_STD || c == cs_pkg::K_GET_STD;
  endfunction

  function automatic logic has_pl(input logic [15:0] c);
    return c == cs_pkg::K_SET_TOFF || c == cs_pkg::K_SET_ALT || c == cs_pkg::K_PRESSURE ||
           c == cs_pkg::K_FRC || c == cs_pkg::K_SET_ASC || c == cs_pkg::K_SET_TGT ||
           c == cs_pkg::K_SET_INIT || c == cs_pkg::K_SET_STD;
  endfunction

  function automatic logic allow(input logic [15:0] c, input logic [1:0] m,
                                 input logic [3:0] v);
    logic r;
    if (is_ext(c) && v == 4'd0) r = 1'b0;
    else if (m == cs_pkg::M_DOWN) r = (c == cs_pkg::K_WAKE);
    else if (m == cs_pkg::M_MEAS)
      r = c == cs_pkg::K_READ_MEAS || c == cs_pkg::K_STOP_PER ||
          c == cs_pkg::K_DREADY || c == cs_pkg::K_PRESSURE;
    else r = c != cs_pkg::K_READ_MEAS && c != cs_pkg::K_WAKE;
    return r;
  endfunction

  always_comb begin
    logic [15:0] c, v, w1;
    logic        one;
    logic [7:0]  rb;
    logic        ack;
    mode_d = mode_q; wcnt_d = wcnt_q; wb_d = wb_q; cmd_d = cmd_q; rsp_d = rsp_q;
    rlen_d = rlen_q; ridx_d = ridx_q; f_dr_d = f_dr_q; f_first_d = f_first_q;
    f_lp_d = f_lp_q; f_ss_d = f_ss_q; f_rht_d = f_rht_q; f_meas_d = f_meas_q;
    f_pers_d = f_pers_q; busy_d = busy_q; mms_d = mms_q; act_d = act_q;
    asc_d = asc_q; sto_d = sto_q;
    mms_dec = mms_q - 15'd1;
    c = {wb_q[0], item_i.data_byte};
    v = {wb_q[2], wb_q[3]};
    w1 = 16'd0; one = 1'b0; rb = 8'd0; ack = 1'b1;
    unique case (item_i.operation)
      cs_pkg::OP_START: begin
        if (busy_q != 14'd0) ack = 1'b0;
        else wcnt_d = 3'd0;
      end
      cs_pkg::OP_WRITE: begin
        if (wcnt_q == 3'd0) begin
          rlen_d = 4'd0; ridx_d = 4'd0;
        end
        if (wcnt_q < 3'd5) begin
          if (wcnt_q < 3'd4) wb_d[wcnt_q[1:0]] = item_i.data_byte;
          wcnt_d = wcnt_q + 3'd1;
        end
        if (wcnt_q == 3'd1) begin
          cmd_d = c;
          if (!has_pl(c) && allow(c, mode_q, variant_i)) begin
            rlen_d = 4'd0; ridx_d = 4'd0;
            unique case (c)
              cs_pkg::K_START_PER: begin
                f_first_d = 1'b0; mode_d = cs_pkg::M_MEAS; f_dr_d = 1'b0;
                f_lp_d = 1'b0; f_ss_d = 1'b0; f_rht_d = 1'b0; mms_d = 15'd5000;
              end
              cs_pkg::K_START_LP: begin
                f_first_d = 1'b0; mode_d = cs_pkg::M_MEAS; f_dr_d = 1'b0;
                f_lp_d = 1'b1; f_ss_d = 1'b0; f_rht_d = 1'b0; mms_d = 15'd30000;
              end
              cs_pkg::K_STOP_PER: begin
                mode_d = cs_pkg::M_IDLE; f_dr_d = 1'b0; f_first_d = 1'b0;
                f_ss_d = 1'b0; f_rht_d = 1'b0; mms_d = 15'd0; busy_d = 14'd500;
              end
              cs_pkg::K_READ_MEAS: begin
                if (f_dr_q) begin
                  w1 = f_rht_q ? 16'd0 : item_i.co2_sample;
                  rsp_d[0] = w1[15:8]; rsp_d[1] = w1[7:0];
                  rsp_d[2] = cs_pkg::crc8(w1[15:8], w1[7:0]);
                  rsp_d[3] = item_i.temp_sample[15:8]; rsp_d[4] = item_i.temp_sample[7:0];
                  rsp_d[5] = cs_pkg::crc8(item_i.temp_sample[15:8],
                                          item_i.temp_sample[7:0]);
                  rsp_d[6] = item_i.humidity_sample[15:8];
                  rsp_d[7] = item_i.humidity_sample[7:0];
                  rsp_d[8] = cs_pkg::crc8(item_i.humidity_sample[15:8],
                                          item_i.humidity_sample[7:0]);
                  rlen_d = 4'd9; f_dr_d = 1'b0;
                  if (f_ss_q) begin
                    mode_d = cs_pkg::M_IDLE; f_ss_d = 1'b0; f_rht_d = 1'b0;
                  end
                end
              end
              cs_pkg::K_SERIAL: begin
                rsp_d[0] = ser_hi_i[15:8]; rsp_d[1] = ser_hi_i[7:0];
                rsp_d[2] = cs_pkg::crc8(ser_hi_i[15:8], ser_hi_i[7:0]);
                rsp_d[3] = ser_mid_i[15:8]; rsp_d[4] = ser_mid_i[7:0];
                rsp_d[5] = cs_pkg::crc8(ser_mid_i[15:8], ser_mid_i[7:0]);
                rsp_d[6] = ser_lo_i[15:8]; rsp_d[7] = ser_lo_i[7:0];
                rsp_d[8] = cs_pkg::crc8(ser_lo_i[15:8], ser_lo_i[7:0]);
                rlen_d = 4'd9;
              end
              cs_pkg::K_DREADY: begin one = 1'b1; w1 = f_dr_q ? 16'h8001 : 16'h0000; end
              cs_pkg::K_GET_TOFF: begin one = 1'b1; w1 = act_q[0]; end
              cs_pkg::K_GET_ALT: begin one = 1'b1; w1 = act_q[1]; end
              cs_pkg::K_GET_ASC: begin one = 1'b1; w1 = {15'd0, asc_q}; end
              cs_pkg::K_VARIANT: begin one = 1'b1; w1 = {variant_i, 12'd0}; end
              cs_pkg::K_GET_TGT: begin one = 1'b1; w1 = act_q[3]; end
              cs_pkg::K_GET_INIT: begin one = 1'b1; w1 = act_q[4]; end
              cs_pkg::K_GET_STD: begin one = 1'b1; w1 = act_q[5]; end
              cs_pkg::K_PERSIST: begin
                sto_d[0] = act_q[0]; sto_d[1] = act_q[1]; sto_d[2] = {15'd0, asc_q};
                sto_d[3] = act_q[3]; sto_d[4] = act_q[4]; sto_d[5] = act_q[5];
                f_pers_d = 1'b1; busy_d = 14'd800;
              end
              cs_pkg::K_SELFTEST: begin one = 1'b1; w1 = 16'd0; busy_d = 14'd10000; end
              cs_pkg::K_FACTORY: begin
                act_d[0] = cs_pkg::DEF_TOFF; act_d[1] = 16'd0; act_d[2] = 16'd0;
                act_d[3] = cs_pkg::DEF_TGT; act_d[4] = cs_pkg::DEF_INIT;
                act_d[5] = cs_pkg::DEF_STD; asc_d = 1'b1;
                sto_d[0] = cs_pkg::DEF_TOFF; sto_d[1] = 16'd0; sto_d[2] = 16'd1;
                sto_d[3] = cs_pkg::DEF_TGT; sto_d[4] = cs_pkg::DEF_INIT;
                sto_d[5] = cs_pkg::DEF_STD;
                f_pers_d = 1'b0; f_meas_d = 1'b0; busy_d = 14'd1200;
              end
              cs_pkg::K_REINIT: begin
                if (f_pers_q) begin
                  act_d[0] = sto_q[0]; act_d[1] = sto_q[1]; asc_d = sto_q[2] != 16'd0;
                  act_d[3] = sto_q[3]; act_d[4] = sto_q[4]; act_d[5] = sto_q[5];
                end else begin
                  act_d[0] = cs_pkg::DEF_TOFF; act_d[1] = 16'd0; act_d[2] = 16'd0;
                  act_d[3] = cs_pkg::DEF_TGT; act_d[4] = cs_pkg::DEF_INIT;
                  act_d[5] = cs_pkg::DEF_STD; asc_d = 1'b1;
                end
                busy_d = 14'd30;
              end
              cs_pkg::K_SINGLE: begin
                mode_d = cs_pkg::M_MEAS; f_dr_d = 1'b0; f_lp_d = 1'b0; f_ss_d = 1'b1;
                f_rht_d = 1'b0; mms_d = 15'd5000; busy_d = 14'd5000;
              end
              cs_pkg::K_SINGLE_RHT: begin
                mode_d = cs_pkg::M_MEAS; f_dr_d = 1'b0; f_lp_d = 1'b0; f_ss_d = 1'b1;
                f_rht_d = 1'b1; mms_d = 15'd50; busy_d = 14'd50;
              end
              cs_pkg::K_PWR_DOWN: mode_d = cs_pkg::M_DOWN;
              cs_pkg::K_WAKE: begin mode_d = cs_pkg::M_IDLE; busy_d = 14'd30; end
              default: ;
            endcase
          end
        end else if (wcnt_q == 3'd4) begin
          if (cs_pkg::crc8(wb_q[2], wb_q[3]) == item_i.data_byte &&
              allow(cmd_q, mode_q, variant_i)) begin
            rlen_d = 4'd0; ridx_d = 4'd0;
            unique case (cmd_q)
              cs_pkg::K_SET_TOFF: act_d[0] = v;
              cs_pkg::K_SET_ALT: act_d[1] = v;
              cs_pkg::K_PRESSURE: act_d[2] = v;
              cs_pkg::K_SET_ASC: asc_d = v != 16'd0;
              cs_pkg::K_SET_TGT: act_d[3] = v;
              cs_pkg::K_SET_INIT: act_d[4] = v;
              cs_pkg::K_SET_STD: act_d[5] = v;
              cs_pkg::K_FRC: begin
                one = 1'b1; w1 = f_meas_q ? 16'h8000 : 16'hFFFF; busy_d = 14'd400;
              end
              default: ;
            endcase
          end
        end
      end
      cs_pkg::OP_READ: begin
        rb = 8'hFF;
        if (mode_q != cs_pkg::M_DOWN && ridx_q < rlen_q && ridx_q < 4'd9) begin
          rb = rsp_q[ridx_q];
          ridx_d = ridx_q + 4'd1;
        end
      end
      cs_pkg::OP_STOP: begin
        if (wcnt_q == 3'd2 && cmd_q == cs_pkg::K_PRESSURE &&
            allow(cmd_q, mode_q, variant_i)) begin
          one = 1'b1; w1 = act_q[2];
        end
        wcnt_d = 3'd0;
      end
      cs_pkg::OP_TICK: begin
        if (busy_q != 14'd0) busy_d = busy_q - 14'd1;
        if (mms_q != 15'd0) begin
          mms_d = mms_dec;
          if (mms_dec == 15'd0) begin
            f_dr_d = 1'b1; f_meas_d = 1'b1;
            if (!f_ss_q) begin
              f_first_d = 1'b1;
              mms_d = f_lp_q ? 15'd30000 : 15'd5000;
            end
          end
        end
      end
      default: ;
    endcase
    if (one) begin
      rsp_d[0] = w1[15:8]; rsp_d[1] = w1[7:0];
      rsp_d[2] = cs_pkg::crc8(w1[15:8], w1[7:0]);
      rlen_d = 4'd3; ridx_d = 4'd0;
    end
    res_o.ack = ack;
    res_o.read_byte = rb;
    res_o.data_ready_flag = f_dr_d;
    res_o.mode = mode_d;
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      wb_q <= wb_d;
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cs_pkg::M_IDLE; wcnt_q <= 3'd0; cmd_q <= 16'd0;
      rlen_q <= 4'd0; ridx_q <= 4'd0;
      f_dr_q <= 1'b0; f_first_q <= 1'b0; f_lp_q <= 1'b0; f_ss_q <= 1'b0;
      f_rht_q <= 1'b0; f_meas_q <= 1'b0; f_pers_q <= 1'b0;
      busy_q <= 14'd0; mms_q <= 15'd0;
      act_q[0] <= cs_pkg::DEF_TOFF; act_q[1] <= 16'd0; act_q[2] <= 16'd0;
      act_q[3] <= cs_pkg::DEF_TGT; act_q[4] <= cs_pkg::DEF_INIT;
      act_q[5] <= cs_pkg::DEF_STD;
      asc_q <= 1'b1;
      for (int i = 0; i < 6; i++) sto_q[i] <= 16'd0;
    end else if (step_i) begin
      mode_q <= mode_d; wcnt_q <= wcnt_d; cmd_q <= cmd_d;
      rlen_q <= rlen_d; ridx_q <= ridx_d;
      f_dr_q <= f_dr_d; f_first_q <= f_first_d; f_lp_q <= f_lp_d; f_ss_q <= f_ss_d;
      f_rht_q <= f_rht_d; f_meas_q <= f_meas_d; f_pers_q <= f_pers_d;
      busy_q <= busy_d; mms_q <= mms_d; act_q <= act_d; asc_q <= asc_d; sto_q <= sto_d;
    end
  end

  a_ridx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ridx_q <= 4'd9) else $error("response index past buffer");
  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= 3'd5) else $error("write count past five");
  a_timer_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mms_q != 15'd0 |-> mode_q == cs_pkg::M_MEAS) else $error("timer runs outside measuring");
  a_nack_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !res_o.ack |-> busy_q != 14'd0 && item_i.operation == cs_pkg::OP_START)
    else $error("NACK without busy start");

endmodule
